FILE: rtl/core/hrxpd_pkg.sv
// ----------------------------------------------------------------------------
// hrxpd_pkg
// Shared types, codes and the palette colour end table of the picture decoder.
// ----------------------------------------------------------------------------
package hrxpd_pkg;

    // default sizes
    localparam int unsigned RUN_TABLE_DEPTH_DEF = 16;
    localparam int unsigned LINE_PIXELS_DEF     = 320;
    localparam int unsigned PICTURE_PIXELS_DEF  = 24320;
    localparam int unsigned TREE_BYTES_DEF      = 256;

    // input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TREE  = 2'd1;
    localparam logic [1:0] OP_BIT   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_QUAD      = 2'd0;
    localparam logic [1:0] ST_UNSUP     = 2'd1;
    localparam logic [1:0] ST_RUN_LARGE = 2'd2;

    // decode phases
    localparam logic [1:0] PH_PALETTE = 2'd0;
    localparam logic [1:0] PH_RUN     = 2'd1;
    localparam logic [1:0] PH_PIXEL   = 2'd2;
    localparam logic [1:0] PH_STOP    = 2'd3;

    // stream constants
    localparam logic [7:0] RLE_TREE_SIZE  = 8'h3e;
    localparam logic [7:0] NO_RUN_CODE_A  = 8'd128;
    localparam logic [7:0] NO_RUN_CODE_B  = 8'd1;
    localparam logic [4:0] BLACK_MIN      = 5'd12;
    localparam logic [4:0] PALETTE_LAST   = 5'd15;

    // one result beat
    typedef struct packed {
        logic [3:0][1:0]  pixel;
        logic [3:0][29:0] colour;
        logic [1:0]       status;
        logic             burst_last;
        logic             picture_done;
    } hrxpd_result_t;

    // dark end of each base colour
    function automatic logic [29:0] colour_dark(input logic [3:0] base);
        logic [29:0] v;
        case (base)
            4'd0:    v = 30'h00000000;
            4'd1:    v = 30'h10420000;
            4'd2:    v = 30'h11419010;
            4'd3:    v = 30'h1751f030;
            4'd4:    v = 30'h12817000;
            4'd5:    v = 30'h124000d8;
            4'd6:    v = 30'h120031b1;
            4'd7:    v = 30'h0141e205;
            4'd8:    v = 30'h02c071e5;
            4'd9:    v = 30'h07429169;
            4'd10:   v = 30'h0004b165;
            4'd11:   v = 30'h00048000;
            4'd12:   v = 30'h05840000;
            4'd13:   v = 30'h0b035000;
            4'd14:   v = 30'h1183a024;
            default: v = 30'h1001a008;
        endcase
        return v;
    endfunction

    // bright end of each base colour
    function automatic logic [29:0] colour_bright(input logic [3:0] base);
        logic [29:0] v;
        case (base)
            4'd0:    v = 30'h3e6f9be6;
            4'd1:    v = 30'h3ffffeaa;
            4'd2:    v = 30'h3ffe6aae;
            4'd3:    v = 30'h3ffdab42;
            4'd4:    v = 30'h3ffcab7a;
            4'd5:    v = 30'h3ffcab7a;
            4'd6:    v = 30'h39ab6bff;
            4'd7:    v = 30'h336d3bff;
            4'd8:    v = 30'h34ed1bff;
            4'd9:    v = 30'h302ebbff;
            4'd10:   v = 30'h31ef6bff;
            4'd11:   v = 30'h336fff36;
            4'd12:   v = 30'h2f2ffe69;
            4'd13:   v = 30'h3caffeae;
            4'd14:   v = 30'h3f6f3afa;
            default: v = 30'h3ffdaa59;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/hrxpd_if.sv
// ----------------------------------------------------------------------------
// hrxpd channel interfaces
// Valid/ready channels for input items and for decoded result beats.
// ----------------------------------------------------------------------------
interface hrxpd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [7:0] tree_position;
    logic       data_bit;

    modport source (output valid, opcode, byte_value, tree_position, data_bit, input ready);
    modport sink   (input valid, opcode, byte_value, tree_position, data_bit, output ready);
endinterface

interface hrxpd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pixel_a;
    logic [1:0]  pixel_b;
    logic [1:0]  pixel_c;
    logic [1:0]  pixel_d;
    logic [29:0] colour_a;
    logic [29:0] colour_b;
    logic [29:0] colour_c;
    logic [29:0] colour_d;
    logic [1:0]  status;
    logic        burst_last;
    logic        picture_done;

    modport source (output valid, pixel_a, pixel_b, pixel_c, pixel_d, colour_a, colour_b,
                    colour_c, colour_d, status, burst_last, picture_done, input ready);
    modport sink   (input valid, pixel_a, pixel_b, pixel_c, pixel_d, colour_a, colour_b,
                    colour_c, colour_d, status, burst_last, picture_done, output ready);
endinterface

FILE: rtl/core/hrxpd_ram.sv
// ----------------------------------------------------------------------------
// hrxpd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hrxpd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/huffman_rle_xor_picture_decoder.sv
// ----------------------------------------------------------------------------
// huffman_rle_xor_picture_decoder
// Huffman tree walk, palette build, run expansion and XOR line decoding.
// ----------------------------------------------------------------------------
// Input items are taken one at a time; ready is high only while the sequencer
// is idle. A data bit that only moves through the tree or buffers a symbol
// costs one tree store read. A fourth symbol runs three codes through the
// sequencer: a palette code is shaded with one multiply per colour channel
// for the first four entries, and a pixel code searches the run table, then
// for each quad does one read and one write of the line store per pixel,
// then the beat. After reset and after each start item the line store is
// cleared, one entry a cycle, through all LINE_PIXELS entries. Result beats
// leave through a one-beat hold stage and an output register, so the final
// beat of a burst is flagged once the item's work is complete.
module huffman_rle_xor_picture_decoder #(
    parameter int unsigned RUN_TABLE_DEPTH = hrxpd_pkg::RUN_TABLE_DEPTH_DEF,
    parameter int unsigned LINE_PIXELS     = hrxpd_pkg::LINE_PIXELS_DEF,
    parameter int unsigned PICTURE_PIXELS  = hrxpd_pkg::PICTURE_PIXELS_DEF,
    parameter int unsigned TREE_BYTES      = hrxpd_pkg::TREE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hrxpd_in_if.sink    in_ch,
    hrxpd_out_if.source out_ch
);

    import hrxpd_pkg::*;

    localparam int unsigned TA_W       = $clog2(TREE_BYTES);
    localparam int unsigned XA_W       = $clog2(LINE_PIXELS);
    localparam int unsigned RT_AW      = $clog2(RUN_TABLE_DEPTH);
    localparam int unsigned QUAD_LIMIT = (PICTURE_PIXELS + 3) / 4;
    localparam int unsigned QC_W       = $clog2(QUAD_LIMIT + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_TREE   = 4'd2;
    localparam logic [3:0] S_CODE   = 4'd3;
    localparam logic [3:0] S_SHADE  = 4'd4;
    localparam logic [3:0] S_SEARCH = 4'd5;
    localparam logic [3:0] S_QUAD   = 4'd6;
    localparam logic [3:0] S_XRD    = 4'd7;
    localparam logic [3:0] S_XWR    = 4'd8;
    localparam logic [3:0] S_QEMIT  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    // control registers
    logic [3:0]      state_reg, state_next;
    logic [1:0]      phase_reg, phase_next;
    logic [7:0]      tree_size_reg, tree_size_next;
    logic [6:0]      node_reg, node_next;
    logic [1:0]      sym_cnt_reg, sym_cnt_next;
    logic [4:0]      pal_cnt_reg, pal_cnt_next;
    logic [4:0]      black_reg, black_next;
    logic [7:0]      run_exp_reg, run_exp_next;
    logic [4:0]      run_cnt_reg, run_cnt_next;
    logic [7:0]      last_code_reg, last_code_next;
    logic [XA_W-1:0] xpos_reg, xpos_next;
    logic [QC_W-1:0] quad_reg, quad_next;
    logic [1:0]      idx_reg, idx_next;
    logic [XA_W-1:0] clr_reg, clr_next;
    logic [1:0]      ch_reg, ch_next;
    logic [1:0]      k_reg, k_next;
    logic [4:0]      srch_reg, srch_next;
    logic [4:0]      rep_reg, rep_next;
    logic            oor_reg, oor_next;
    logic            out_valid_reg, out_valid_next;
    logic            pend_valid_reg, pend_valid_next;

    // payload registers
    logic [2:0][7:0]  sym_reg, sym_next;
    logic [7:0]       tops_reg, tops_next;
    logic [7:0]       code_reg, code_next;
    logic [3:0][29:0] pal_reg, pal_next;
    logic [7:0]       rt_reg [RUN_TABLE_DEPTH];
    logic [7:0]       rt_next [RUN_TABLE_DEPTH];
    logic [29:0]      shade_reg, shade_next;
    logic [1:0]       pidx_reg, pidx_next;
    logic [3:0][1:0]  px_reg, px_next;
    hrxpd_result_t    out_reg, out_next;
    hrxpd_result_t    pend_reg, pend_next;

    // memory ports
    logic            tram_we;
    logic [7:0]      tram_rdata;
    logic [7:0]      taddr;
    logic            xram_we;
    logic [XA_W-1:0] xram_waddr;
    logic [1:0]      xram_wdata;
    logic [1:0]      xram_rdata;

    // working signals
    logic          accept;
    logic          out_free;
    logic          can_emit;
    logic          emit_req;
    logic          fin_push;
    hrxpd_result_t emit_data;
    logic [7:0]    branch;
    logic [7:0]    cur_code;
    logic [4:0]    black_inc;
    logic [7:0]    run_first;
    logic [3:0]    adv_state;
    logic          halted;
    logic [29:0]   lo_end;
    logic [29:0]   hi_end;
    logic [9:0]    sh_dark;
    logic [9:0]    sh_bright;
    logic [13:0]   sh_prod;
    logic [9:0]    sh_val;
    logic [1:0]    pix_raw;
    logic [1:0]    pix_xor;
    logic [XA_W-1:0] xpos_inc;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign can_emit = !pend_valid_reg || out_free;
    assign halted   = (phase_reg == PH_STOP) || (quad_reg >= QC_W'(QUAD_LIMIT));
    assign taddr    = {node_reg, ~in_ch.data_bit};
    assign branch   = oor_reg ? 8'd0 : tram_rdata;
    assign in_ch.ready = (state_reg == S_IDLE);

    // tree node store
    hrxpd_ram #(.WIDTH(8), .DEPTH(TREE_BYTES)) u_tree_ram (
        .clk   (clk),
        .we    (tram_we),
        .waddr (in_ch.tree_position[TA_W-1:0]),
        .wdata (in_ch.byte_value),
        .raddr (taddr[TA_W-1:0]),
        .rdata (tram_rdata)
    );

    // xor line store
    hrxpd_ram #(.WIDTH(2), .DEPTH(LINE_PIXELS)) u_line_ram (
        .clk   (clk),
        .we    (xram_we),
        .waddr (xram_waddr),
        .wdata (xram_wdata),
        .raddr (xpos_reg),
        .rdata (xram_rdata)
    );

    // code assembled from a buffered symbol and its two top bits
    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_code = {tops_reg[5:4], sym_reg[0][5:0]};
            2'd1:    cur_code = {tops_reg[3:2], sym_reg[1][5:0]};
            default: cur_code = {tops_reg[1:0], sym_reg[2][5:0]};
        endcase
        cur_code[5:0] = sym_reg[idx_reg][5:0];
        cur_code[7:6] = cur_code[7:6] | sym_reg[idx_reg][7:6];
    end

    assign black_inc = black_reg + ((cur_code == 8'd0) ? 5'd1 : 5'd0);
    assign run_first = ((cur_code == NO_RUN_CODE_A) || (cur_code == NO_RUN_CODE_B)) ?
                       8'd0 : cur_code;
    assign adv_state = (idx_reg == 2'd2) ? S_FIN : S_CODE;
    assign xpos_inc  = (xpos_reg == XA_W'(LINE_PIXELS - 1)) ? '0 : xpos_reg + 1'b1;

    // shared channel interpolator: one 10x4 multiply a cycle
    always_comb
    begin
        lo_end    = colour_dark(code_reg[7:4]);
        hi_end    = colour_bright(code_reg[7:4]);
        sh_dark   = lo_end[ch_reg * 10 +: 10];
        sh_bright = hi_end[ch_reg * 10 +: 10];
        sh_prod   = 14'(sh_bright - sh_dark) * 14'(code_reg[3:0]);
        sh_val    = (sh_bright >= sh_dark) ? sh_dark + sh_prod[13:4] : sh_dark;
    end

    // pixel of the literal code and its xor with the line store
    assign pix_raw = last_code_reg[6 - 2 * k_reg +: 2];
    assign pix_xor = xram_rdata ^ pix_raw;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        tree_size_next  = tree_size_reg;
        node_next       = node_reg;
        sym_cnt_next    = sym_cnt_reg;
        pal_cnt_next    = pal_cnt_reg;
        black_next      = black_reg;
        run_exp_next    = run_exp_reg;
        run_cnt_next    = run_cnt_reg;
        last_code_next  = last_code_reg;
        xpos_next       = xpos_reg;
        quad_next       = quad_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        ch_next         = ch_reg;
        k_next          = k_reg;
        srch_next       = srch_reg;
        rep_next        = rep_reg;
        oor_next        = oor_reg;
        sym_next        = sym_reg;
        tops_next       = tops_reg;
        code_next       = code_reg;
        pal_next        = pal_reg;
        rt_next         = rt_reg;
        shade_next      = shade_reg;
        pidx_next       = pidx_reg;
        px_next         = px_reg;
        emit_req        = 1'b0;
        emit_data       = '0;
        fin_push        = 1'b0;
        tram_we         = 1'b0;
        xram_we         = 1'b0;
        xram_waddr      = xpos_reg;
        xram_wdata      = 2'd0;

        unique case (state_reg)
            S_CLEAR:
            begin
                xram_we    = 1'b1;
                xram_waddr = clr_reg;
                if (clr_reg == XA_W'(LINE_PIXELS - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.opcode)
                        OP_START:
                        begin
                            tree_size_next = in_ch.byte_value;
                            node_next      = '0;
                            sym_cnt_next   = '0;
                            phase_next     = PH_PALETTE;
                            pal_cnt_next   = '0;
                            black_next     = '0;
                            run_exp_next   = '0;
                            run_cnt_next   = '0;
                            last_code_next = '0;
                            xpos_next      = '0;
                            quad_next      = '0;
                            clr_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        OP_TREE:
                        begin
                            tram_we = ({1'b0, in_ch.tree_position} < 9'(TREE_BYTES));
                        end
                        OP_BIT:
                        begin
                            if (!halted)
                            begin
                                oor_next   = ({1'b0, taddr} >= 9'(TREE_BYTES));
                                state_next = S_TREE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_TREE:
            begin
                if (branch[7])
                begin
                    node_next  = branch[6:0];
                    state_next = S_IDLE;
                end
                else
                begin
                    node_next = '0;
                    if (sym_cnt_reg != 2'd3)
                    begin
                        sym_next[sym_cnt_reg] = branch;
                        sym_cnt_next          = sym_cnt_reg + 1'b1;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        sym_cnt_next = '0;
                        tops_next    = branch;
                        idx_next     = '0;
                        state_next   = S_CODE;
                    end
                end
            end

            S_CODE:
            begin
                idx_next = idx_reg + 1'b1;
                case (phase_reg)
                    PH_PALETTE:
                    begin
                        if ((pal_cnt_reg == PALETTE_LAST) && (black_inc < BLACK_MIN))
                        begin
                            // palette too colourful: stop the picture
                            emit_req         = 1'b1;
                            emit_data.status = ST_UNSUP;
                            idx_next         = idx_reg;
                            if (can_emit)
                            begin
                                phase_next = PH_STOP;
                                state_next = S_FIN;
                            end
                        end
                        else
                        begin
                            pal_cnt_next = pal_cnt_reg + 1'b1;
                            black_next   = black_inc;
                            if (pal_cnt_reg == PALETTE_LAST)
                            begin
                                phase_next = (tree_size_reg == RLE_TREE_SIZE) ?
                                             PH_RUN : PH_PIXEL;
                            end
                            if (pal_cnt_reg < 5'd4)
                            begin
                                code_next  = cur_code;
                                pidx_next  = pal_cnt_reg[1:0];
                                ch_next    = '0;
                                shade_next = '0;
                                idx_next   = idx_reg;
                                state_next = S_SHADE;
                            end
                            else
                            begin
                                state_next = adv_state;
                            end
                        end
                    end

                    PH_RUN:
                    begin
                        if (run_exp_reg == 8'd0)
                        begin
                            if (run_first > 8'(RUN_TABLE_DEPTH))
                            begin
                                emit_req         = 1'b1;
                                emit_data.status = ST_RUN_LARGE;
                                idx_next         = idx_reg;
                                if (can_emit)
                                begin
                                    phase_next = PH_STOP;
                                    state_next = S_FIN;
                                end
                            end
                            else
                            begin
                                run_exp_next = run_first;
                                run_cnt_next = '0;
                                if (run_first == 8'd0)
                                begin
                                    phase_next = PH_PIXEL;
                                end
                                state_next = adv_state;
                            end
                        end
                        else
                        begin
                            if (run_cnt_reg < 5'(RUN_TABLE_DEPTH))
                            begin
                                rt_next[run_cnt_reg[RT_AW-1:0]] = cur_code;
                                run_cnt_next                    = run_cnt_reg + 1'b1;
                            end
                            if (run_exp_reg == {3'b000, run_cnt_next})
                            begin
                                phase_next = PH_PIXEL;
                            end
                            state_next = adv_state;
                        end
                    end

                    PH_PIXEL:
                    begin
                        code_next  = cur_code;
                        srch_next  = '0;
                        rep_next   = '0;
                        idx_next   = idx_reg;
                        state_next = S_SEARCH;
                    end

                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_SHADE:
            begin
                shade_next[ch_reg * 10 +: 10] = sh_val;
                if (ch_reg == 2'd2)
                begin
                    pal_next[pidx_reg] = shade_next;
                    idx_next           = idx_reg + 1'b1;
                    state_next         = adv_state;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end

            S_SEARCH:
            begin
                // highest matching run table position wins
                if (srch_reg < run_cnt_reg)
                begin
                    if (rt_reg[srch_reg[RT_AW-1:0]] == code_reg)
                    begin
                        rep_next = srch_reg + 1'b1;
                    end
                    srch_next = srch_reg + 1'b1;
                end
                else
                begin
                    if (rep_reg == 5'd0)
                    begin
                        last_code_next = code_reg;
                        rep_next       = 5'd1;
                    end
                    state_next = S_QUAD;
                end
            end

            S_QUAD:
            begin
                if ((rep_reg == 5'd0) || (quad_reg >= QC_W'(QUAD_LIMIT)))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = adv_state;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_XRD;
                end
            end

            S_XRD:
            begin
                state_next = S_XWR;
            end

            S_XWR:
            begin
                xram_we         = 1'b1;
                xram_wdata      = pix_xor;
                px_next[k_reg]  = (run_exp_reg != 8'd0) ? pix_xor : pix_raw;
                xpos_next       = xpos_inc;
                k_next          = k_reg + 1'b1;
                state_next      = (k_reg == 2'd3) ? S_QEMIT : S_XRD;
            end

            S_QEMIT:
            begin
                emit_req               = 1'b1;
                emit_data.status       = ST_QUAD;
                emit_data.pixel        = px_reg;
                emit_data.colour[0]    = pal_reg[px_reg[0]];
                emit_data.colour[1]    = pal_reg[px_reg[1]];
                emit_data.colour[2]    = pal_reg[px_reg[2]];
                emit_data.colour[3]    = pal_reg[px_reg[3]];
                emit_data.picture_done = ((quad_reg + 1'b1) >= QC_W'(QUAD_LIMIT));
                if (can_emit)
                begin
                    quad_next  = quad_reg + 1'b1;
                    rep_next   = rep_reg - 1'b1;
                    state_next = S_QUAD;
                end
            end

            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    fin_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold stage and output register: a beat is flagged last at step end
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (emit_req && can_emit)
        begin
            if (pend_valid_reg)
            begin
                out_next            = pend_reg;
                out_next.burst_last = 1'b0;
                out_valid_next      = 1'b1;
            end
            pend_next       = emit_data;
            pend_valid_next = 1'b1;
        end
        if (fin_push)
        begin
            out_next            = pend_reg;
            out_next.burst_last = 1'b1;
            out_valid_next      = 1'b1;
            pend_valid_next     = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            phase_reg      <= PH_PALETTE;
            tree_size_reg  <= '0;
            node_reg       <= '0;
            sym_cnt_reg    <= '0;
            pal_cnt_reg    <= '0;
            black_reg      <= '0;
            run_exp_reg    <= '0;
            run_cnt_reg    <= '0;
            last_code_reg  <= '0;
            xpos_reg       <= '0;
            quad_reg       <= '0;
            idx_reg        <= '0;
            clr_reg        <= '0;
            ch_reg         <= '0;
            k_reg          <= '0;
            srch_reg       <= '0;
            rep_reg        <= '0;
            oor_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            tree_size_reg  <= tree_size_next;
            node_reg       <= node_next;
            sym_cnt_reg    <= sym_cnt_next;
            pal_cnt_reg    <= pal_cnt_next;
            black_reg      <= black_next;
            run_exp_reg    <= run_exp_next;
            run_cnt_reg    <= run_cnt_next;
            last_code_reg  <= last_code_next;
            xpos_reg       <= xpos_next;
            quad_reg       <= quad_next;
            idx_reg        <= idx_next;
            clr_reg        <= clr_next;
            ch_reg         <= ch_next;
            k_reg          <= k_next;
            srch_reg       <= srch_next;
            rep_reg        <= rep_next;
            oor_reg        <= oor_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        tops_reg  <= tops_next;
        code_reg  <= code_next;
        pal_reg   <= pal_next;
        rt_reg    <= rt_next;
        shade_reg <= shade_next;
        pidx_reg  <= pidx_next;
        px_reg    <= px_next;
        out_reg   <= out_next;
        pend_reg  <= pend_next;
    end

    // output port
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pixel_a      = out_reg.pixel[0];
    assign out_ch.pixel_b      = out_reg.pixel[1];
    assign out_ch.pixel_c      = out_reg.pixel[2];
    assign out_ch.pixel_d      = out_reg.pixel[3];
    assign out_ch.colour_a     = out_reg.colour[0];
    assign out_ch.colour_b     = out_reg.colour[1];
    assign out_ch.colour_c     = out_reg.colour[2];
    assign out_ch.colour_d     = out_reg.colour[3];
    assign out_ch.status       = out_reg.status;
    assign out_ch.burst_last   = out_reg.burst_last;
    assign out_ch.picture_done = out_reg.picture_done;

    // a status beat always ends its burst
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status != ST_QUAD)) |-> out_ch.burst_last)
        else $error("status beat not flagged last");

    // the final quad of the picture ends its burst
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.picture_done) |-> out_ch.burst_last)
        else $error("picture done beat not flagged last");

    // quad count never runs past the picture
    a_quad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        quad_reg <= QC_W'(QUAD_LIMIT))
        else $error("quad count beyond picture");

    // line position stays inside the line store
    a_xpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        xpos_reg < XA_W'(LINE_PIXELS))
        else $error("line position out of range");

    // no input item is taken with a beat still held back
    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !pend_valid_reg)
        else $error("held beat left behind at idle");

endmodule
